### rtl/multi_joint_pid_controller_core_macros.svh
// Assertion macros for the multi-joint PID controller core.
// Used by the top level only; empty bodies when SYNTH is defined.
`ifndef MULTI_JOINT_PID_CONTROLLER_CORE_MACROS_SVH
`define MULTI_JOINT_PID_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTH
`define MJPID_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mjpid: same-cycle check failed");
`define MJPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mjpid: next-cycle check failed");
`else
`define MJPID_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define MJPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/mjpid_pkg.sv
// Shared types, widths, reset values and helpers for the PID controller core.
// No dependencies; used by every module of the block.
package mjpid_pkg;

    localparam int JOINTS_DEFAULT = 6;

    localparam int JOINT_W     = 3;
    localparam int ANGLE_W     = 16;
    localparam int STEP_W      = 16;
    localparam int ERR_W       = 17;
    localparam int DIFF_W      = 18;
    localparam int INT_W       = 48;
    localparam int GAIN_W      = 32;
    localparam int LIM_W       = 16;
    localparam int OPND_W      = 33;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int SUM_W       = 65;
    localparam int ACC_W       = 51;
    localparam int V_W         = ACC_W - 24;
    localparam int MAG_W       = 50;
    localparam int QUOT_W      = 48;
    localparam int DIV_STEPS   = QUOT_W / 2;
    localparam int OVF_SH      = 31;
    localparam int JOINT_CMP_W = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MEM_W       = INT_W + ERR_W;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 24;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST        = 32'sd1677722;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST        = 32'sd16777;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST        = 32'sd8389;
    localparam logic signed [LIM_W-1:0]  DRIVE_UPPER_RST   = 16'sd1434;
    localparam logic signed [LIM_W-1:0]  DRIVE_LOWER_RST   = -16'sd1434;
    localparam logic [JOINT_W-1:0]       SPECIAL_JOINT_RST = 3'd4;
    localparam logic signed [LIM_W-1:0]  SPECIAL_UPPER_RST = 16'sd4096;
    localparam logic signed [LIM_W-1:0]  SPECIAL_LOWER_RST = -16'sd4096;

    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(INT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO  = SUM_W'(INT_MIN);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_DRIVE_UPPER,
        CFG_DRIVE_LOWER,
        CFG_SPECIAL_JOINT,
        CFG_SPECIAL_UPPER,
        CFG_SPECIAL_LOWER
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INT,
        S_ISUM,
        S_P,
        S_IHI,
        S_ILO,
        S_ISAT,
        S_DSTART,
        S_DWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic ovf;
    } t_div_status;

    function automatic logic signed [INT_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [INT_W-1:0] r;
        if (v > SAT_HI) begin
            r = INT_MAX;
        end else if (v < SAT_LO) begin
            r = INT_MIN;
        end else begin
            r = v[INT_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/mjpid_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on mjpid_pkg for default sizes.
module mjpid_ram #(
    parameter int WIDTH = mjpid_pkg::MEM_W,
    parameter int DEPTH = mjpid_pkg::JOINTS_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mjpid_div.sv
// Radix-4 restoring divider for the derivative term: floor(mag * 2^16 / step).
// Flags overflow past 2^47 up front. Depends on mjpid_pkg.
module mjpid_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mjpid_pkg::MAG_W-1:0]   i_mag,
    input  logic [mjpid_pkg::STEP_W-1:0]  i_step,
    output mjpid_pkg::t_div_status        o_status,
    output logic [mjpid_pkg::QUOT_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(mjpid_pkg::DIV_STEPS);
    localparam int OVF_W = mjpid_pkg::MAG_W - mjpid_pkg::OVF_SH;
    localparam int SW    = mjpid_pkg::STEP_W;
    localparam int QW    = mjpid_pkg::QUOT_W;

    logic             r_busy;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic [SW-1:0]    r_rem;
    logic [QW-1:0]    r_dq;

    logic          ovf;
    logic [SW:0]   t1;
    logic [SW:0]   t2;
    logic          ge1;
    logic          ge2;
    logic [SW-1:0] r1;
    logic [SW-1:0] r2;

    assign ovf = i_mag[mjpid_pkg::MAG_W-1:mjpid_pkg::OVF_SH] >= OVF_W'(i_step);

    always_comb begin
        t1  = {r_rem, r_dq[QW-1]};
        ge1 = t1 >= {1'b0, i_step};
        r1  = ge1 ? SW'(t1 - {1'b0, i_step}) : t1[SW-1:0];
        t2  = {r1, r_dq[QW-2]};
        ge2 = t2 >= {1'b0, i_step};
        r2  = ge2 ? SW'(t2 - {1'b0, i_step}) : t2[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= !ovf;
        end else if (r_busy && (r_cnt == CNT_W'(mjpid_pkg::DIV_STEPS - 1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= ovf;
            r_cnt <= '0;
            r_rem <= i_mag[QW-1:QW-SW];
            r_dq  <= {i_mag[QW-SW-1:0], {SW{1'b0}}};
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= r2;
            r_dq  <= {r_dq[QW-3:0], ge1, ge2};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.ovf  = r_ovf;
    assign o_quot        = r_dq;

endmodule

### rtl/multi_joint_pid_controller_core.sv
// Multi-joint PID velocity controller: one shared datapath, per-joint state in RAM.
// Depends on mjpid_pkg, mjpid_ram, mjpid_div and the assertion macro header.
//
// One transfer in gives one transfer out. Each sample for a joint in range is read from
// the state RAM, updates its integral and goes through the shared 33x33 multiplies,
// then the derivative divider, which delivers two quotient bits per cycle and is
// skipped when the quotient saturates. A joint number beyond the table returns drive 0.
// One sample is worked at a time; the next is taken as soon as the result sits in
// the output register. Integrator and previous-error state clear at reset through
// per-joint valid bits, so there is no clearing pass.
`include "multi_joint_pid_controller_core_macros.svh"

module multi_joint_pid_controller_core #(
    parameter int JOINTS = mjpid_pkg::JOINTS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // joint_index[2:0], demand_angle[18:3], measured_angle[34:19], step_time[50:35]
    input  logic [mjpid_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_joint[2:0], drive[18:3], clamped[19]
    output logic [mjpid_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [mjpid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mjpid_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int JW  = mjpid_pkg::JOINT_W;
    localparam int EW  = mjpid_pkg::ERR_W;
    localparam int IW  = mjpid_pkg::INT_W;
    localparam int GW  = mjpid_pkg::GAIN_W;
    localparam int LW  = mjpid_pkg::LIM_W;
    localparam int OW  = mjpid_pkg::OPND_W;
    localparam int PW  = mjpid_pkg::PROD_W;
    localparam int SW  = mjpid_pkg::SUM_W;
    localparam int CW  = mjpid_pkg::ACC_W;
    localparam int VW  = mjpid_pkg::V_W;
    localparam int MW  = mjpid_pkg::MAG_W;
    localparam int QW  = mjpid_pkg::QUOT_W;
    localparam int XW  = mjpid_pkg::JOINT_CMP_W;

    // configuration
    logic signed [GW-1:0] r_gain_p;
    logic signed [GW-1:0] r_gain_i;
    logic signed [GW-1:0] r_gain_d;
    logic signed [LW-1:0] r_drive_upper;
    logic signed [LW-1:0] r_drive_lower;
    logic [JW-1:0]        r_special_joint;
    logic signed [LW-1:0] r_special_upper;
    logic signed [LW-1:0] r_special_lower;

    // sequencer and datapath
    mjpid_pkg::t_state r_state;
    mjpid_pkg::t_state n_state;

    logic [JW-1:0]           r_joint;
    logic                    r_oob;
    logic [AW-1:0]           r_addr;
    logic signed [EW-1:0]    r_err;
    logic [mjpid_pkg::STEP_W-1:0] r_step;
    logic signed [EW-1:0]    r_last;
    logic signed [IW-1:0]    r_integ;
    logic signed [mjpid_pkg::DIFF_W-1:0] r_diff;
    logic signed [PW-1:0]    r_prod;
    logic signed [PW-3:0]    r_ihi;
    logic signed [SW-1:0]    r_isum;
    logic signed [CW-1:0]    r_acc;
    logic                    r_neg;
    logic [MW-1:0]           r_mag;
    logic [JOINTS-1:0]       r_valid;
    logic                    r_out_valid;
    logic [mjpid_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                    accept;
    logic                    in_range;
    logic [JW-1:0]           in_joint;
    logic signed [LW-1:0]    in_demand;
    logic signed [LW-1:0]    in_measured;
    logic                    out_free;
    logic                    out_load;
    logic                    mem_re;
    logic                    mem_we;
    logic [mjpid_pkg::MEM_W-1:0] mem_rdata;
    logic                    div_start;
    mjpid_pkg::t_div_status  div_status;
    logic [QW-1:0]           div_quot;
    logic signed [OW-1:0]    mul_a;
    logic signed [OW-1:0]    mul_b;
    logic signed [IW-1:0]    integ_next;
    logic signed [IW-1:0]    d_term;
    logic signed [VW-1:0]    v;
    logic signed [VW-1:0]    lim_up;
    logic signed [VW-1:0]    lim_dn;
    logic signed [LW-1:0]    drive;
    logic                    clamped;

    assign in_joint    = s_axis_tdata[2:0];
    assign in_demand   = s_axis_tdata[18:3];
    assign in_measured = s_axis_tdata[34:19];
    assign accept      = s_axis_tvalid && s_axis_tready;
    assign in_range    = XW'(in_joint) < XW'(JOINTS);
    assign out_free    = !r_out_valid || m_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p        <= mjpid_pkg::GAIN_P_RST;
            r_gain_i        <= mjpid_pkg::GAIN_I_RST;
            r_gain_d        <= mjpid_pkg::GAIN_D_RST;
            r_drive_upper   <= mjpid_pkg::DRIVE_UPPER_RST;
            r_drive_lower   <= mjpid_pkg::DRIVE_LOWER_RST;
            r_special_joint <= mjpid_pkg::SPECIAL_JOINT_RST;
            r_special_upper <= mjpid_pkg::SPECIAL_UPPER_RST;
            r_special_lower <= mjpid_pkg::SPECIAL_LOWER_RST;
        end else if (i_cfg_we) begin
            unique case (mjpid_pkg::t_cfg_idx'(i_cfg_index))
                mjpid_pkg::CFG_GAIN_P:        r_gain_p        <= i_cfg_data;
                mjpid_pkg::CFG_GAIN_I:        r_gain_i        <= i_cfg_data;
                mjpid_pkg::CFG_GAIN_D:        r_gain_d        <= i_cfg_data;
                mjpid_pkg::CFG_DRIVE_UPPER:   r_drive_upper   <= i_cfg_data[LW-1:0];
                mjpid_pkg::CFG_DRIVE_LOWER:   r_drive_lower   <= i_cfg_data[LW-1:0];
                mjpid_pkg::CFG_SPECIAL_JOINT: r_special_joint <= i_cfg_data[JW-1:0];
                mjpid_pkg::CFG_SPECIAL_UPPER: r_special_upper <= i_cfg_data[LW-1:0];
                mjpid_pkg::CFG_SPECIAL_LOWER: r_special_lower <= i_cfg_data[LW-1:0];
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mjpid_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = in_range ? mjpid_pkg::S_INT : mjpid_pkg::S_DONE;
                end
            end
            mjpid_pkg::S_INT:    n_state = mjpid_pkg::S_ISUM;
            mjpid_pkg::S_ISUM:   n_state = mjpid_pkg::S_P;
            mjpid_pkg::S_P:      n_state = mjpid_pkg::S_IHI;
            mjpid_pkg::S_IHI:    n_state = mjpid_pkg::S_ILO;
            mjpid_pkg::S_ILO:    n_state = mjpid_pkg::S_ISAT;
            mjpid_pkg::S_ISAT:   n_state = mjpid_pkg::S_DSTART;
            mjpid_pkg::S_DSTART: n_state = mjpid_pkg::S_DWAIT;
            mjpid_pkg::S_DWAIT: begin
                if (!div_status.busy) begin
                    n_state = mjpid_pkg::S_DONE;
                end
            end
            mjpid_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = mjpid_pkg::S_IDLE;
                end
            end
            default: n_state = mjpid_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs and multiplier operands
    always_comb begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            mjpid_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                mem_re        = accept && in_range;
            end
            mjpid_pkg::S_INT: begin
                mul_a = OW'(r_err);
                mul_b = $signed({{(OW-mjpid_pkg::STEP_W){1'b0}}, r_step});
            end
            mjpid_pkg::S_ISUM: begin
                mem_we = 1'b1;
                mul_a  = OW'(r_gain_p);
                mul_b  = OW'(r_err);
            end
            mjpid_pkg::S_P: begin
                mul_a = OW'(r_gain_i);
                mul_b = OW'($signed(r_integ[IW-1:16]));
            end
            mjpid_pkg::S_IHI: begin
                mul_a = OW'(r_gain_i);
                mul_b = $signed({{(OW-16){1'b0}}, r_integ[15:0]});
            end
            mjpid_pkg::S_ILO: begin
                mul_a = OW'(r_gain_d);
                mul_b = OW'(r_diff);
            end
            mjpid_pkg::S_DSTART: div_start = 1'b1;
            mjpid_pkg::S_DONE:   out_load  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mjpid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign integ_next = mjpid_pkg::sat48(SW'(r_integ) + SW'($signed(r_prod[OW-1:0])));

    always_comb begin
        if (r_step == '0) begin
            d_term = '0;
        end else if (div_status.ovf) begin
            d_term = r_neg ? mjpid_pkg::INT_MIN : mjpid_pkg::INT_MAX;
        end else begin
            d_term = r_neg ? -$signed(div_quot) : $signed(div_quot);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            mjpid_pkg::S_IDLE: begin
                if (accept) begin
                    r_joint <= in_joint;
                    r_oob   <= !in_range;
                    r_addr  <= AW'(in_joint);
                    r_err   <= EW'(in_demand) - EW'(in_measured);
                    r_step  <= s_axis_tdata[50:35];
                end
            end
            mjpid_pkg::S_INT: begin
                r_integ <= r_valid[r_addr] ? $signed(mem_rdata[mjpid_pkg::MEM_W-1:EW]) : '0;
                r_last  <= r_valid[r_addr] ? $signed(mem_rdata[EW-1:0]) : '0;
            end
            mjpid_pkg::S_ISUM: begin
                r_integ <= integ_next;
                r_diff  <= mjpid_pkg::DIFF_W'(r_err) - mjpid_pkg::DIFF_W'(r_last);
            end
            mjpid_pkg::S_P:   r_acc <= CW'($signed(r_prod[48:0]));
            mjpid_pkg::S_IHI: r_ihi <= r_prod[PW-3:0];
            mjpid_pkg::S_ILO: r_isum <= SW'(r_ihi) + SW'($signed(r_prod[48:16]));
            mjpid_pkg::S_ISAT: begin
                r_acc <= r_acc + CW'(mjpid_pkg::sat48(r_isum));
                r_neg <= r_prod[PW-1];
                r_mag <= r_prod[PW-1] ? MW'(-r_prod) : MW'(r_prod);
            end
            mjpid_pkg::S_DWAIT: begin
                if (!div_status.busy) begin
                    r_acc <= r_acc + CW'(d_term);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    mjpid_ram #(
        .WIDTH (mjpid_pkg::MEM_W),
        .DEPTH (JOINTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata ({integ_next, r_err}),
        .i_re    (mem_re),
        .i_raddr (AW'(in_joint)),
        .o_rdata (mem_rdata)
    );

    mjpid_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_mag    (r_mag),
        .i_step   (r_step),
        .o_status (div_status),
        .o_quot   (div_quot)
    );

    // output clamp; upper limit tested first
    always_comb begin
        v = $signed(r_acc[CW-1:24]);
        if (r_joint == r_special_joint) begin
            lim_up = VW'(r_special_upper);
            lim_dn = VW'(r_special_lower);
        end else begin
            lim_up = VW'(r_drive_upper);
            lim_dn = VW'(r_drive_lower);
        end
        if (r_oob) begin
            drive   = '0;
            clamped = 1'b0;
        end else if (v > lim_up) begin
            drive   = lim_up[LW-1:0];
            clamped = 1'b1;
        end else if (v < lim_dn) begin
            drive   = lim_dn[LW-1:0];
            clamped = 1'b1;
        end else begin
            drive   = v[LW-1:0];
            clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {4'b0, clamped, drive, r_joint};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `MJPID_ASSERT_IMPLIES(a_read_before_use, i_clk, i_rst_n, r_state == mjpid_pkg::S_INT, $past(mem_re))
    `MJPID_ASSERT_IMPLIES(a_div_start_idle, i_clk, i_rst_n, div_start, !div_status.busy)
    `MJPID_ASSERT_NEXT(a_result_waits, i_clk, i_rst_n, (r_state == mjpid_pkg::S_DONE) && r_out_valid && !m_axis_tready, r_state == mjpid_pkg::S_DONE)
    `MJPID_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, accept, !s_axis_tready)

endmodule

### tb/multi_joint_pid_controller_core_tb.sv
// Self-checking testbench for multi_joint_pid_controller_core: directed rows, then phases of
// random samples under changing gains and limits, with random stalls on both stream sides.
// Depends on mjpid_pkg and the RTL of the core only.
module multi_joint_pid_controller_core_tb;
    import mjpid_pkg::*;

    localparam int     STALL_LIMIT = 3000;
    localparam int     PHASES      = 12;
    localparam int     PHASE_ITEMS = 100;
    localparam longint LIM47_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LIM47_LO    = -LIM47_HI - 64'sd1;

    typedef struct packed {
        logic [2:0]         joint;
        logic signed [15:0] demand;
        logic signed [15:0] measured;
        logic [15:0]        step;
    } sample_t;

    typedef struct packed {
        logic [2:0]         joint;
        logic signed [15:0] drive;
        logic               clamped;
    } drive_t;

    typedef struct {
        sample_t s;
        bit      pin;
        drive_t  want;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bit     steady = 1'b0;
    bit     row_pinned = 1'b0;
    drive_t row_want = '0;
    int     mismatches = 0;
    int     quiet_cycles = 0;

    // predictor copy of registers and per-joint state
    logic signed [31:0] kp, ki, kd;
    logic signed [15:0] lim_hi, lim_lo, alt_hi, alt_lo;
    logic [2:0]         alt_joint;
    longint             integ_mem [JOINTS_DEFAULT];
    longint             prev_err [JOINTS_DEFAULT];

    drive_t    pending_drives [$];
    stim_row_t stim_rows [$];

    multi_joint_pid_controller_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint clip47(input longint v);
        if (v > LIM47_HI) return LIM47_HI;
        if (v < LIM47_LO) return LIM47_LO;
        return v;
    endfunction

    // derivative term: gain_d * diff * 2^16 / step, truncated, magnitude saturated
    function automatic longint deriv(input longint diff, input longint unsigned step);
        longint          q;
        longint unsigned mag, whole, part, res;
        if (step == 0) return 0;
        q = longint'(kd) * diff;
        mag = (q < 0) ? -q : q;
        whole = mag / step;
        if (whole >= (64'd1 << 31)) begin
            res = 64'd1 << 47;
        end else begin
            part = ((mag % step) << 16) / step;
            res = (whole << 16) + part;
            if (res > (64'd1 << 47)) res = 64'd1 << 47;
        end
        if (q < 0) return -longint'(res);
        if (res > 64'(LIM47_HI)) res = 64'(LIM47_HI);
        return longint'(res);
    endfunction

    function automatic drive_t pid_update(input sample_t s);
        drive_t r;
        longint err, step, acc, ihi, ilo, iterm, v, up, dn;
        r.joint = s.joint;
        r.drive = '0;
        r.clamped = 1'b0;
        if (s.joint >= JOINTS_DEFAULT) return r;
        err = longint'(s.demand) - longint'(s.measured);
        step = longint'(s.step);
        acc = clip47(integ_mem[s.joint] + err * step);
        integ_mem[s.joint] = acc;
        ihi = acc >>> 16;
        ilo = acc & 64'hFFFF;
        iterm = clip47(longint'(ki) * ihi + ((longint'(ki) * ilo) >>> 16));
        v = (longint'(kp) * err + iterm + deriv(err - prev_err[s.joint], s.step)) >>> 24;
        up = (s.joint == alt_joint) ? longint'(alt_hi) : longint'(lim_hi);
        dn = (s.joint == alt_joint) ? longint'(alt_lo) : longint'(lim_lo);
        if (v > up) begin
            v = up;
            r.clamped = 1'b1;
        end else if (v < dn) begin
            v = dn;
            r.clamped = 1'b1;
        end
        prev_err[s.joint] = err;
        r.drive = 16'(v);
        return r;
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 29);
    end

    // register mirror, prediction on input transfers, checking on output transfers
    always @(posedge i_clk) begin
        sample_t s;
        drive_t  want, got;
        if (!i_rst_n) begin
            kp = GAIN_P_RST;
            ki = GAIN_I_RST;
            kd = GAIN_D_RST;
            lim_hi = DRIVE_UPPER_RST;
            lim_lo = DRIVE_LOWER_RST;
            alt_joint = SPECIAL_JOINT_RST;
            alt_hi = SPECIAL_UPPER_RST;
            alt_lo = SPECIAL_LOWER_RST;
            for (int j = 0; j < JOINTS_DEFAULT; j++) begin
                integ_mem[j] = 0;
                prev_err[j] = 0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_P:        kp = i_cfg_data;
                    CFG_GAIN_I:        ki = i_cfg_data;
                    CFG_GAIN_D:        kd = i_cfg_data;
                    CFG_DRIVE_UPPER:   lim_hi = i_cfg_data[15:0];
                    CFG_DRIVE_LOWER:   lim_lo = i_cfg_data[15:0];
                    CFG_SPECIAL_JOINT: alt_joint = i_cfg_data[2:0];
                    CFG_SPECIAL_UPPER: alt_hi = i_cfg_data[15:0];
                    CFG_SPECIAL_LOWER: alt_lo = i_cfg_data[15:0];
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.joint = m_axis_tdata[2:0];
                got.drive = m_axis_tdata[18:3];
                got.clamped = m_axis_tdata[19];
                if (pending_drives.size() == 0) begin
                    $display("%0t: unexpected output transfer, actual %0d/%0d/%0d", $time,
                             got.joint, got.drive, got.clamped);
                    mismatches++;
                end else begin
                    want = pending_drives.pop_front();
                    if (got !== want) begin
                        $display("%0t: joint/drive/clamped expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                                 $time, want.joint, want.drive, want.clamped,
                                 got.joint, got.drive, got.clamped);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                s.joint = s_axis_tdata[2:0];
                s.demand = s_axis_tdata[18:3];
                s.measured = s_axis_tdata[34:19];
                s.step = s_axis_tdata[50:35];
                want = pid_update(s);
                if (row_pinned) want = row_want;
                pending_drives.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic void add_row(input logic [2:0] joint, input logic [15:0] dem,
                                    input logic [15:0] mea, input logic [15:0] step,
                                    input bit pin, input logic [15:0] drive,
                                    input logic clamped);
        stim_row_t r;
        r.s = {joint, dem, mea, step};
        r.pin = pin;
        r.want = {joint, drive, clamped};
        stim_rows.push_back(r);
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      off;
        s.joint = ($urandom_range(99) < 6) ? $urandom_range(7, 6) : $urandom_range(5, 0);
        s.demand = $urandom();
        if ($urandom_range(1)) begin
            s.measured = $urandom();
        end else begin
            off = $urandom_range(1 << $urandom_range(12, 0));
            s.measured = $urandom_range(1) ? s.demand + off : s.demand - off;
        end
        case ($urandom_range(4))
            0:       s.step = '0;
            1:       s.step = $urandom_range(64, 1);
            2:       s.step = $urandom_range(2500, 1800);
            3:       s.step = $urandom();
            default: s.step = $urandom_range(1) ? 16'hFFFF : 16'd1;
        endcase
        return s;
    endfunction

    task automatic send_sample(input sample_t s, input bit pin, input drive_t want);
        while (!steady && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, s.step, s.measured, s.demand, s.joint};
        row_pinned <= pin;
        row_want <= want;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_drives.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_phase(input int k);
        logic signed [31:0] gp, gi, gd;
        logic signed [15:0] up, lo, su, sl, t;
        logic [2:0]         sj;
        case (k)
            1: begin
                gp = 32'sd838861; gi = 32'sd167772; gd = 32'sd16777;
                up = 16'h7FFF; lo = 16'h8000; sj = 3'd0; su = 16'sd2048; sl = -16'sd2048;
            end
            2: begin
                gp = 32'h7FFF_FFFF; gi = 32'h7FFF_FFFF; gd = 32'h7FFF_FFFF;
                up = 16'h7FFF; lo = 16'h8000; sj = 3'd5; su = 16'h7FFF; sl = 16'h8000;
            end
            3: begin
                gp = 32'h8000_0000; gi = 32'h8000_0000; gd = 32'h8000_0000;
                up = DRIVE_UPPER_RST; lo = DRIVE_LOWER_RST; sj = 3'd7;
                su = SPECIAL_UPPER_RST; sl = SPECIAL_LOWER_RST;
            end
            4: begin
                // crossed limits everywhere; special index names no joint
                gp = GAIN_P_RST; gi = GAIN_I_RST; gd = GAIN_D_RST;
                up = -16'sd100; lo = 16'sd100; sj = 3'd6; su = 16'h8000; sl = 16'h7FFF;
            end
            5: begin
                gp = '0; gi = '0; gd = '0;
                up = '0; lo = '0; sj = 3'd1; su = -16'sd1; sl = 16'sd1;
            end
            6: begin
                gp = GAIN_P_RST; gi = GAIN_I_RST; gd = GAIN_D_RST;
                up = DRIVE_UPPER_RST; lo = DRIVE_LOWER_RST; sj = SPECIAL_JOINT_RST;
                su = SPECIAL_UPPER_RST; sl = SPECIAL_LOWER_RST;
            end
            default: begin
                gp = $signed($urandom()) >>> $urandom_range(31, 0);
                gi = $signed($urandom()) >>> $urandom_range(31, 0);
                gd = $signed($urandom()) >>> $urandom_range(31, 0);
                up = $urandom(); lo = $urandom(); su = $urandom(); sl = $urandom();
                sj = $urandom_range(7);
                if ($urandom_range(99) < 85 && up < lo) begin
                    t = up; up = lo; lo = t;
                end
                if ($urandom_range(99) < 85 && su < sl) begin
                    t = su; su = sl; sl = t;
                end
            end
        endcase
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_DRIVE_UPPER, {16'b0, up});
        write_reg(CFG_DRIVE_LOWER, {16'b0, lo});
        write_reg(CFG_SPECIAL_JOINT, {29'b0, sj});
        write_reg(CFG_SPECIAL_UPPER, {16'b0, su});
        write_reg(CFG_SPECIAL_LOWER, {16'b0, sl});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        // reset register values; zero step keeps I and D at zero for the pinned rows
        add_row(3'd0, 16'h7FFF, 16'h8000, 16'd0,     1'b1, 16'sd1434,  1'b1);
        add_row(3'd1, 16'h8000, 16'h7FFF, 16'd0,     1'b1, -16'sd1434, 1'b1);
        add_row(3'd4, 16'h7FFF, 16'h8000, 16'd0,     1'b1, 16'sd4096,  1'b1);
        add_row(3'd4, 16'h8000, 16'h7FFF, 16'd0,     1'b1, -16'sd4096, 1'b1);
        add_row(3'd2, 16'd0,    16'd0,    16'd0,     1'b1, 16'sd0,     1'b0);
        add_row(3'd3, 16'd0,    16'd0,    16'hFFFF,  1'b1, 16'sd0,     1'b0);
        // joint numbers past the table
        add_row(3'd6, 16'd1234, 16'hFFFB, 16'd100,   1'b1, 16'sd0,     1'b0);
        add_row(3'd7, 16'hFFFF, 16'h7FFF, 16'hFFFF,  1'b1, 16'sd0,     1'b0);
        add_row(3'd0, 16'd0,    16'd0,    16'hFFFF,  1'b0, '0, 1'b0);
        add_row(3'd0, 16'h7FFF, 16'h8000, 16'hFFFF,  1'b0, '0, 1'b0);
        add_row(3'd0, 16'h7FFF, 16'h8000, 16'd1,     1'b0, '0, 1'b0);
        add_row(3'd1, 16'h7FFF, 16'h8000, 16'd1,     1'b0, '0, 1'b0);
        add_row(3'd1, 16'h8000, 16'h7FFF, 16'd1,     1'b0, '0, 1'b0);
        add_row(3'd5, 16'd100,  16'd90,   16'd2184,  1'b0, '0, 1'b0);
        add_row(3'd5, 16'd120,  16'd90,   16'd2184,  1'b0, '0, 1'b0);
        add_row(3'd3, 16'hFF38, 16'd0,    16'd2184,  1'b0, '0, 1'b0);
        add_row(3'd2, 16'd1,    16'd0,    16'd1,     1'b0, '0, 1'b0);
        add_row(3'd2, 16'hFFFF, 16'd0,    16'hFFFF,  1'b0, '0, 1'b0);
        add_row(3'd4, 16'd4096, 16'd0,    16'd2184,  1'b0, '0, 1'b0);
        add_row(3'd5, 16'h8000, 16'h8000, 16'h8000,  1'b0, '0, 1'b0);
        add_row(3'd4, 16'h8000, 16'd0,    16'd3,     1'b0, '0, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[n]) begin
            send_sample(stim_rows[n].s, stim_rows[n].pin, stim_rows[n].want);
        end

        for (int k = 1; k <= PHASES; k++) begin
            s_axis_tvalid <= 1'b0;
            wait_drained();
            repeat (3) @(posedge i_clk);
            steady <= (k == 6);
            apply_phase(k);
            repeat (PHASE_ITEMS) begin
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
